// ===== design/postfix_expression_evaluator_top_assert.svh =====
// Assertion macros used by the checker file of the postfix evaluator.
// Every macro is sampled on the rising clock edge and disabled during reset.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_TOP_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_TOP_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold in the same cycle.
`define PEE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("postfix evaluator: same-cycle check failed");

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define PEE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("postfix evaluator: next-cycle check failed");

`endif

// ===== design/pee_pkg.sv =====
// ----------------------------------------------------------------------------
// pee_pkg
// Shared types and constants for the postfix expression evaluator.
// ----------------------------------------------------------------------------
package pee_pkg;

    // Datapath and field widths
    localparam int DATA_W          = 32;
    localparam int SYM_W           = 8;
    localparam int STATUS_W        = 3;
    localparam int STACK_DEPTH_DEF = 64;

    typedef logic [DATA_W-1:0] word_t;
    typedef logic [SYM_W-1:0]  sym_t;

    // Value returned by a pop from an empty stack (-32767)
    localparam word_t EMPTY_POP_VALUE = 32'hFFFF_8001;

    // Character codes
    localparam sym_t SYM_ZERO = 8'h30;  // '0'
    localparam sym_t SYM_ADD  = 8'h2B;  // '+'
    localparam sym_t SYM_SUB  = 8'h2D;  // '-'
    localparam sym_t SYM_MUL  = 8'h2A;  // '*'
    localparam sym_t SYM_DIV  = 8'h2F;  // '/'

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_DIVZERO   = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    // Operator held while an operator request is worked on
    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } op_t;

endpackage

// ===== design/pee_ram.sv =====
// ----------------------------------------------------------------------------
// pee_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/pee_div.sv =====
// ----------------------------------------------------------------------------
// pee_div
// Signed 32-bit divider, quotient truncated toward zero. Radix-2 restoring
// on magnitudes, one quotient bit per cycle; done pulses with the quotient.
// ----------------------------------------------------------------------------
module pee_div (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  pee_pkg::word_t dividend,
    input  pee_pkg::word_t divisor,
    output logic          done,
    output pee_pkg::word_t quotient
);

    localparam int W  = pee_pkg::DATA_W;
    localparam int CW = $clog2(W);

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic           neg_reg,  neg_next;
    logic [CW-1:0]  cnt_reg,  cnt_next;
    pee_pkg::word_t rem_reg,  rem_next;
    pee_pkg::word_t quo_reg,  quo_next;
    pee_pkg::word_t dvs_reg,  dvs_next;

    logic [W:0]     shifted;
    logic [W:0]     diff;

    // One restoring step
    always_comb
    begin
        shifted = {rem_reg, quo_reg[W-1]};
        diff    = shifted - {1'b0, dvs_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            neg_next  = dividend[W-1] ^ divisor[W-1];
            cnt_next  = CW'(W - 1);
            rem_next  = '0;
            quo_next  = dividend[W-1] ? (~dividend + W'(1)) : dividend;
            dvs_next  = divisor[W-1] ? (~divisor + W'(1)) : divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers, no reset
    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + W'(1)) : quo_reg;

endmodule

// ===== design/postfix_expression_evaluator_top.sv =====
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_top
// Postfix evaluator over a RAM-held operand stack, one character per request.
// ----------------------------------------------------------------------------
// Each request carries one character. An operand request's value is written
// straight into the stack RAM, and the top entry is also kept in a register.
// An operator request for + - and * passes through accept, RAM read of the
// left operand, and execute and write back; the RAM read is skipped when
// fewer than two entries remain. A / with a nonzero divisor waits for the
// radix-2 divider, which retires one quotient bit per cycle. A request
// flagged last also passes through S_DONE to load the result register and holds
// off the next request until that register is free. The stack RAM needs no
// clearing pass after reset; only entries below the stack level are ever read.
module postfix_expression_evaluator_top #(
    parameter int STACK_DEPTH = pee_pkg::STACK_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [pee_pkg::SYM_W-1:0]           symbol,
    input  logic                                last,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [pee_pkg::DATA_W-1:0]   value,
    output logic [pee_pkg::STATUS_W-1:0]        status
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LW = $clog2(STACK_DEPTH + 1);

    typedef logic [LW-1:0] level_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_DIV,
        S_DONE
    } state_t;

    state_t           state_reg,     state_next;
    level_t           level_reg,     level_next;
    pee_pkg::status_t err_reg,       err_next;
    logic             out_valid_reg, out_valid_next;
    pee_pkg::word_t   top_reg,       top_next;
    pee_pkg::word_t   left_reg,      left_next;
    pee_pkg::word_t   right_reg,     right_next;
    pee_pkg::word_t   res_reg,       res_next;
    pee_pkg::word_t   value_reg,     value_next;
    pee_pkg::status_t status_reg,    status_next;
    pee_pkg::op_t     op_reg,        op_next;
    logic             last_reg,      last_next;

    // Stack RAM ports
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    pee_pkg::word_t   ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    pee_pkg::word_t   ram_rdata;

    // Divider ports
    logic             div_start;
    logic             div_done;
    pee_pkg::word_t   div_q;

    // Decode and helpers
    logic             is_op;
    pee_pkg::op_t     op_dec;
    pee_pkg::word_t   operand;
    level_t           level_m2;
    logic             level_full;
    logic             level_ge2;

    always_comb
    begin
        is_op  = 1'b1;
        op_dec = pee_pkg::OP_ADD;
        case (symbol)
            pee_pkg::SYM_ADD: op_dec = pee_pkg::OP_ADD;
            pee_pkg::SYM_SUB: op_dec = pee_pkg::OP_SUB;
            pee_pkg::SYM_MUL: op_dec = pee_pkg::OP_MUL;
            pee_pkg::SYM_DIV: op_dec = pee_pkg::OP_DIV;
            default:          is_op  = 1'b0;
        endcase
    end

    assign operand    = pee_pkg::word_t'(symbol) - pee_pkg::word_t'(pee_pkg::SYM_ZERO);
    assign level_m2   = level_reg - level_t'(2);
    assign level_full = (level_reg >= level_t'(STACK_DEPTH));
    assign level_ge2  = (level_reg >= level_t'(2));

    // Control and datapath next state
    always_comb
    begin
        logic           push_do;
        pee_pkg::word_t push_val;

        state_next     = state_reg;
        level_next     = level_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;
        top_next       = top_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        res_next       = res_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        op_next        = op_reg;
        last_next      = last_reg;
        ram_we         = 1'b0;
        ram_waddr      = level_reg[AW-1:0];
        ram_wdata      = operand;
        ram_re         = 1'b0;
        ram_raddr      = level_m2[AW-1:0];
        div_start      = 1'b0;
        push_do        = 1'b0;
        push_val       = '0;

        // Output register drains on its own
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (is_op)
                    begin
                        // Pop right from the top register and left from RAM; a missing entry pops EMPTY_POP_VALUE
                        op_next    = op_dec;
                        last_next  = last;
                        right_next = (level_reg != '0) ? top_reg : pee_pkg::EMPTY_POP_VALUE;
                        if (!level_ge2 && err_reg == pee_pkg::ST_OK)
                        begin
                            err_next = pee_pkg::ST_UNDERFLOW;
                        end
                        if (level_ge2)
                        begin
                            level_next = level_m2;
                            ram_re     = 1'b1;
                            state_next = S_READ;
                        end
                        else
                        begin
                            level_next = '0;
                            left_next  = pee_pkg::EMPTY_POP_VALUE;
                            state_next = S_EXEC;
                        end
                    end
                    else
                    begin
                        // Operand push, dropped when full
                        if (!level_full)
                        begin
                            ram_we     = 1'b1;
                            ram_wdata  = operand;
                            top_next   = operand;
                            level_next = level_reg + level_t'(1);
                        end
                        else if (err_reg == pee_pkg::ST_OK)
                        begin
                            err_next = pee_pkg::ST_OVERFLOW;
                        end
                        if (last)
                        begin
                            res_next   = level_full ? top_reg : operand;
                            state_next = S_DONE;
                        end
                    end
                end
            end

            S_READ:
            begin
                left_next  = ram_rdata;
                state_next = S_EXEC;
            end

            S_EXEC:
            begin
                case (op_reg)
                    pee_pkg::OP_ADD:
                    begin
                        push_do  = 1'b1;
                        push_val = left_reg + right_reg;
                    end
                    pee_pkg::OP_SUB:
                    begin
                        push_do  = 1'b1;
                        push_val = left_reg - right_reg;
                    end
                    pee_pkg::OP_MUL:
                    begin
                        push_do  = 1'b1;
                        push_val = left_reg * right_reg;
                    end
                    pee_pkg::OP_DIV:
                    begin
                        if (right_reg == '0)
                        begin
                            push_do  = 1'b1;
                            push_val = '0;
                            if (err_reg == pee_pkg::ST_OK)
                            begin
                                err_next = pee_pkg::ST_DIVZERO;
                            end
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    push_do  = 1'b1;
                    push_val = div_q;
                end
            end

            S_DONE:
            begin
                // Load result once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    value_next     = res_reg;
                    status_next    = err_reg;
                    level_next     = '0;
                    err_next       = pee_pkg::ST_OK;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Operator result write-back; at most STACK_DEPTH-2 entries remain here
        if (push_do)
        begin
            ram_we     = 1'b1;
            ram_wdata  = push_val;
            top_next   = push_val;
            level_next = level_reg + level_t'(1);
            res_next   = push_val;
            state_next = last_reg ? S_DONE : S_IDLE;
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            level_reg     <= '0;
            err_reg       <= pee_pkg::ST_OK;
            out_valid_reg <= 1'b0;
            value_reg     <= '0;
            status_reg    <= pee_pkg::ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
            value_reg     <= value_next;
            status_reg    <= status_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        top_reg    <= top_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
        res_reg    <= res_next;
        op_reg     <= op_next;
        last_reg   <= last_next;
    end

    pee_ram #(
        .WIDTH (pee_pkg::DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pee_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (left_reg),
        .divisor  (right_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign value     = $signed(value_reg);
    assign status    = status_reg;

endmodule

// ===== design/pee_checker.sv =====
// ----------------------------------------------------------------------------
// pee_checker
// Port-level checks for the postfix evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`include "postfix_expression_evaluator_top_assert.svh"

module pee_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic [pee_pkg::SYM_W-1:0]         symbol,
    input logic                              last,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [pee_pkg::DATA_W-1:0] value,
    input logic [pee_pkg::STATUS_W-1:0]      status
);

    // A stalled result holds its payload
    `PEE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(value) && $stable(status))

    // The last request always leaves the stack non-empty, so status is never ST_EMPTY
    `PEE_ASSERT_NOW(a_status_range, clk, rst_n, out_valid, status != pee_pkg::ST_EMPTY)

    // A request that is not last never produces a result
    `PEE_ASSERT_NEXT(a_no_early_result, clk, rst_n, in_valid && in_ready && !last, !$rose(out_valid))

    // After a last request the input is held off while the result is built
    `PEE_ASSERT_NEXT(a_last_stalls, clk, rst_n, in_valid && in_ready && last, !in_ready)

endmodule

bind postfix_expression_evaluator_top pee_checker u_pee_checker (.*);
